// ----- rtl/rtt_pkg.sv -----
// Shared types and codes for the repeating timer table.
package rtt_pkg;

    // command codes on the func field
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_ADD   = 3'd1;
    localparam logic [2:0] FUNC_DEL   = 3'd2;
    localparam logic [2:0] FUNC_POP   = 3'd3;
    localparam logic [2:0] FUNC_QUERY = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISS    = 2'd1;
    localparam logic [1:0] STAT_NOT_DUE = 2'd2;

    // largest handle that fits in the 5-bit handle fields
    localparam int MAX_HANDLES = 31;

    // widths of the stream payloads
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // one timer entry as held in the slot memory
    typedef struct packed {
        logic [15:0] interval;
        logic [31:0] deadline;
        logic [15:0] remaining;
        logic [31:0] age;
    } slot_entry_t;

endpackage

// ----- rtl/repeating_timer_table.sv -----
// Top level of the repeating timer table: command decode, slot memory and scan engine.
//
// Usage:
//   Requests arrive on the s_ stream channel (func, interval, repeat_count,
//   handle packed in s_tdata) and each one gives exactly one result on the
//   m_ stream channel (handle_out, min_wait, status packed in m_tdata).
//   Tick, add and delete work from the slot valid flags and the current time
//   alone: the request passes through the exec state and the result is then
//   registered; no new request is taken until the block is idle again.
//   Pop and query sweep the slot memory one entry per cycle through its
//   single registered read port, then pop writes the chosen entry back in
//   the finish state, where the result is registered; only USED slots are
//   swept, where USED is min(SLOTS,31), and no new request is taken meanwhile.
//   A request is taken whenever the engine is idle, even while the previous
//   result still waits in the output register; if the receiver stalls, the
//   engine holds its finished result (and any write back) until the output
//   register frees up.
//   Reset clears the current time, the add sequence, all slot valid flags
//   and both channel handshakes. The slot memory needs no clearing pass:
//   entries are only used for slots whose valid flag is set.
module repeating_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata, low to high: func[2:0], interval[18:3], repeat_count[34:19],
    // handle[39:35]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rtt_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata, low to high: handle_out[4:0], min_wait[21:5], status[23:22]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rtt_pkg::M_TDATA_W-1:0] m_tdata
);
    import rtt_pkg::*;

    // slots actually used: every handle must fit in 5 bits
    localparam int USED = (SLOTS < MAX_HANDLES) ? SLOTS : MAX_HANDLES;
    localparam int IDXW = $clog2(USED);
    localparam int CW   = $clog2(USED + 1);

    // engine states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // control state
    logic [1:0]      state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            rd_pend_reg;
    logic            found_reg, found_next;
    logic [31:0]     now_reg, now_next;
    logic [31:0]     seq_reg, seq_next;
    logic [USED-1:0] valid_reg, valid_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // request registers
    logic [2:0]      func_reg;
    logic [15:0]     interval_reg;
    logic [15:0]     repeat_reg;
    logic [4:0]      handle_reg;

    // scan bookkeeping
    logic [IDXW-1:0] rd_slot_reg;
    logic [IDXW-1:0] best_slot_reg, best_slot_next;
    logic [31:0]     best_dist_reg, best_dist_next;
    logic [15:0]     best_wait_reg, best_wait_next;
    slot_entry_t     best_entry_reg, best_entry_next;

    // output register fields
    logic [4:0]      out_handle_reg, out_handle_next;
    logic [16:0]     out_wait_reg, out_wait_next;
    logic [1:0]      out_status_reg, out_status_next;

    // slot memory
    slot_entry_t     mem [USED];
    slot_entry_t     mem_rdata_reg;
    logic [IDXW-1:0] mem_raddr;
    logic            mem_we;
    logic [IDXW-1:0] mem_waddr;
    slot_entry_t     mem_wdata;

    logic            accept;
    logic            out_free;
    logic            issue;

    // per-entry evaluation during the sweep
    logic [31:0]     diff;
    logic            due;
    logic [31:0]     recency;
    logic [15:0]     wclamp;
    logic            slot_v;

    // add and delete helpers
    logic            free_any;
    logic [IDXW-1:0] free_idx;
    logic [4:0]      del_idx;
    logic            del_ok;
    logic [15:0]     rem_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign issue    = (state_reg == ST_SCAN) && (cnt_reg != CW'(USED));
    assign mem_raddr = cnt_reg[IDXW-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_status_reg, out_wait_reg, out_handle_reg};

    // wrap-safe wait and recency of the entry just read
    assign diff    = mem_rdata_reg.deadline - now_reg;
    assign due     = diff[31] || (diff == 32'd0);
    assign recency = seq_reg - mem_rdata_reg.age;
    assign slot_v  = valid_reg[rd_slot_reg];
    assign wclamp  = diff[31] ? 16'd0 : ((|diff[31:16]) ? 16'hFFFF : diff[15:0]);

    // lowest free slot for add
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = USED - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDXW'(i);
            end
        end
    end

    assign del_idx = handle_reg - 5'd1;
    assign del_ok  = (handle_reg != 5'd0) && (handle_reg <= 5'(USED))
                     && valid_reg[del_idx[IDXW-1:0]];

    // positive counts step down, negative counts repeat forever
    assign rem_new = ((best_entry_reg.remaining != 16'd0) && !best_entry_reg.remaining[15])
                     ? best_entry_reg.remaining - 16'd1 : best_entry_reg.remaining;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        now_next        = now_reg;
        seq_next        = seq_reg;
        valid_next      = valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        best_slot_next  = best_slot_reg;
        best_dist_next  = best_dist_reg;
        best_wait_next  = best_wait_reg;
        best_entry_next = best_entry_reg;
        out_handle_next = out_handle_reg;
        out_wait_next   = out_wait_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wdata       = '{interval:  interval_reg,
                            deadline:  now_reg + 32'(interval_reg),
                            remaining: repeat_reg,
                            age:       seq_reg};

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    if (s_tdata[2:0] == FUNC_POP || s_tdata[2:0] == FUNC_QUERY) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next      = ST_IDLE;
                    m_tvalid_next   = 1'b1;
                    out_handle_next = 5'd0;
                    out_wait_next   = 17'd0;
                    out_status_next = STAT_OK;
                    case (func_reg)
                        FUNC_TICK: begin
                            now_next = now_reg + 32'd1;
                        end
                        FUNC_ADD: begin
                            if (free_any) begin
                                mem_we                = 1'b1;
                                valid_next[free_idx]  = 1'b1;
                                seq_next              = seq_reg + 32'd1;
                                out_handle_next       = 5'(free_idx) + 5'd1;
                            end else begin
                                out_status_next = STAT_MISS;
                            end
                        end
                        FUNC_DEL: begin
                            if (del_ok) begin
                                valid_next[del_idx[IDXW-1:0]] = 1'b0;
                                out_handle_next               = handle_reg;
                            end else begin
                                out_status_next = STAT_MISS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (rd_pend_reg && slot_v) begin
                    if (func_reg == FUNC_POP) begin
                        if (due && (!found_reg || recency < best_dist_reg)) begin
                            found_next      = 1'b1;
                            best_dist_next  = recency;
                            best_slot_next  = rd_slot_reg;
                            best_entry_next = mem_rdata_reg;
                        end
                    end else begin
                        if (!found_reg || wclamp < best_wait_reg) begin
                            found_next     = 1'b1;
                            best_wait_next = wclamp;
                        end
                    end
                end
                // last entry evaluated: result is settled next cycle
                if (!issue && rd_pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next      = ST_IDLE;
                    m_tvalid_next   = 1'b1;
                    out_handle_next = 5'd0;
                    out_wait_next   = 17'd0;
                    out_status_next = STAT_OK;
                    if (func_reg == FUNC_POP) begin
                        if (found_reg) begin
                            // reload the served timer and write it back
                            mem_we    = 1'b1;
                            mem_waddr = best_slot_reg;
                            mem_wdata = '{interval:  best_entry_reg.interval,
                                          deadline:  now_reg + 32'(best_entry_reg.interval),
                                          remaining: rem_new,
                                          age:       best_entry_reg.age};
                            if (rem_new == 16'd0) begin
                                valid_next[best_slot_reg] = 1'b0;
                            end
                            out_handle_next = 5'(best_slot_reg) + 5'd1;
                        end else begin
                            out_status_next = STAT_NOT_DUE;
                        end
                    end else begin
                        out_wait_next = found_reg ? {1'b0, best_wait_reg} : 17'h1FFFF;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            found_reg    <= 1'b0;
            now_reg      <= '0;
            seq_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_pend_reg  <= issue;
            found_reg    <= found_next;
            now_reg      <= now_next;
            seq_reg      <= seq_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_tdata[2:0];
            interval_reg <= s_tdata[18:3];
            repeat_reg   <= s_tdata[34:19];
            handle_reg   <= s_tdata[39:35];
        end
        rd_slot_reg    <= mem_raddr;
        best_slot_reg  <= best_slot_next;
        best_dist_reg  <= best_dist_next;
        best_wait_reg  <= best_wait_next;
        best_entry_reg <= best_entry_next;
        out_handle_reg <= out_handle_next;
        out_wait_reg   <= out_wait_next;
        out_status_reg <= out_status_next;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

`ifndef SYNTHESIS
    // the finish step is only entered from the sweep
    a_finish_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |->
            ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_FINISH))
        else $error("finish state entered without a sweep");

    // memory is written only by add or by a pop write back
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_EXEC || state_reg == ST_FINISH))
        else $error("slot memory written outside exec or finish");

    // a new result is produced only when a command completes
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |->
            ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_FINISH))
        else $error("result raised without a completing command");

    // the sweep counter never runs past the used slots
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CW'(USED)))
        else $error("sweep counter out of range");
`endif

endmodule

// ----- test/repeating_timer_table_tb.sv -----
// Self-checking stream testbench for the repeating timer table.
module repeating_timer_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtt_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int SLOTS = 16;
    // handles are slot numbers plus one, so only the slots that fit a 5-bit handle are used
    localparam int USED_SLOTS = (SLOTS < MAX_HANDLES) ? SLOTS : MAX_HANDLES;
    // func codes above FUNC_QUERY up to this one do nothing
    localparam logic [2:0] FUNC_SPARE_LAST = 3'd7;
    // drain margin: room for a pop or query sweep plus a held result
    localparam int DRAIN_CYCLES = 2 * USED_SLOTS + 8;
    // receiver hold-off that fills the output register and the engine
    localparam int HOLD_OFF_CYCLES = 300;
    // longest stretch without any handshake: the hold-off plus generous slack
    localparam int STUCK_LIMIT = 2000;
    localparam int PRINT_CAP = 200;

    // one request as it travels in s_tdata
    typedef struct {
        logic [2:0]         func;
        logic [15:0]        interval;
        logic signed [15:0] repeat_count;
        logic [4:0]         handle;
    } timer_req_t;

    // one result as it travels in m_tdata
    typedef struct {
        logic [4:0]         handle_out;
        logic signed [16:0] min_wait;
        logic [1:0]         status;
    } timer_res_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // expected timer table contents, mirrored request by request
    logic [31:0] tick_now;
    logic [31:0] add_seq;
    bit          slot_busy   [USED_SLOTS];
    logic [15:0] slot_period [USED_SLOTS];
    logic [31:0] slot_due    [USED_SLOTS];
    logic [15:0] slot_left   [USED_SLOTS];
    logic [31:0] slot_birth  [USED_SLOTS];

    // results still owed by the block, oldest first
    timer_res_t pending_results[$];

    int mismatches = 0;
    int results_seen = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int stuck_cycles = 0;

    // hold-off handshake between the test sequence and the receiver process
    bit hold_trigger = 1'b0;
    bit hold_ack = 1'b0;
    int hold_left = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    repeating_timer_table #(
        .SLOTS(SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // func, interval, repeat_count, handle
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // handle_out, min_wait, status
    );

    // Apply one request to the mirrored table and return the result it must produce.
    function automatic timer_res_t timer_table_step(timer_req_t r);
        timer_res_t         res;
        bit                 found;
        int                 pick;
        int                 h;
        int                 nearest;
        int                 w;
        logic [31:0]        recency;
        logic [31:0]        best_dist;
        logic signed [31:0] wait_raw;
        res.handle_out = '0;
        res.min_wait = '0;
        res.status = STAT_OK;
        found = 1'b0;
        pick = 0;
        best_dist = '0;
        case (r.func)
            FUNC_TICK: begin
                tick_now = tick_now + 32'd1;
            end
            FUNC_ADD: begin
                // lowest free slot wins; none free means the table is full
                res.status = STAT_MISS;
                for (int s = 0; s < USED_SLOTS; s++) begin
                    if (!found && !slot_busy[s]) begin
                        found = 1'b1;
                        slot_busy[s] = 1'b1;
                        slot_period[s] = r.interval;
                        slot_due[s] = tick_now + 32'(r.interval);
                        slot_left[s] = r.repeat_count;
                        slot_birth[s] = add_seq;
                        add_seq = add_seq + 32'd1;
                        res.handle_out = 5'(s + 1);
                        res.status = STAT_OK;
                    end
                end
            end
            FUNC_DEL: begin
                h = r.handle;
                if (h >= 1 && h <= USED_SLOTS && slot_busy[h - 1]) begin
                    slot_busy[h - 1] = 1'b0;
                    res.handle_out = r.handle;
                end else begin
                    res.status = STAT_MISS;
                end
            end
            FUNC_POP: begin
                // due when deadline minus now, read as signed, is not positive;
                // the newest timer has the smallest distance to the add sequence
                for (int s = 0; s < USED_SLOTS; s++) begin
                    wait_raw = slot_due[s] - tick_now;
                    if (slot_busy[s] && wait_raw <= 0) begin
                        recency = add_seq - slot_birth[s];
                        if (!found || recency < best_dist) begin
                            found = 1'b1;
                            best_dist = recency;
                            pick = s;
                        end
                    end
                end
                if (!found) begin
                    res.status = STAT_NOT_DUE;
                end else begin
                    slot_due[pick] = tick_now + 32'(slot_period[pick]);
                    // negative counts repeat forever
                    if (slot_left[pick] != 16'd0 && !slot_left[pick][15])
                        slot_left[pick] = slot_left[pick] - 16'd1;
                    if (slot_left[pick] == 16'd0)
                        slot_busy[pick] = 1'b0;
                    res.handle_out = 5'(pick + 1);
                end
            end
            FUNC_QUERY: begin
                nearest = -1;
                for (int s = 0; s < USED_SLOTS; s++) begin
                    if (slot_busy[s]) begin
                        wait_raw = slot_due[s] - tick_now;
                        w = wait_raw;
                        if (w < 0)
                            w = 0;
                        if (w > 65535)
                            w = 65535;
                        if (nearest < 0 || w < nearest)
                            nearest = w;
                    end
                end
                res.min_wait = 17'(nearest);
            end
            default: begin
                // spare codes leave everything alone
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got_v, int want_v);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: result %0d: %s got %0d, expected %0d",
                     $realtime, results_seen, what, got_v, want_v);
    endtask

    // Offer one request, with a random gap first when the sender idles, and
    // log its expected result once the block takes it. tvalid stays high on return.
    task automatic send_request(logic [2:0] func, logic [15:0] interval,
                                logic signed [15:0] repeat_count, logic [4:0] handle);
        timer_req_t r;
        r.func = func;
        r.interval = interval;
        r.repeat_count = repeat_count;
        r.handle = handle;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.handle, r.repeat_count, r.interval, r.func};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(timer_table_step(r));
    endtask

    // Drop tvalid, wait for every owed result, then let any sweep settle.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed timer traffic: ticks move time so timers come due,
    // deletes mostly hit live handles, intervals mostly short.
    function automatic timer_req_t random_request();
        timer_req_t r;
        int         roll;
        int         live;
        int         k;
        roll = $urandom_range(99);
        if (roll < 70)
            r.interval = 16'($urandom_range(6));
        else if (roll < 90)
            r.interval = 16'($urandom_range(40));
        else
            r.interval = 16'($urandom_range(16'hffff));
        roll = $urandom_range(99);
        if (roll < 15)
            r.repeat_count = -16'sd1;
        else if (roll < 25)
            r.repeat_count = 16'(16'h8000 | $urandom_range(16'h7fff));
        else if (roll < 35)
            r.repeat_count = 16'sd0;
        else if (roll < 85)
            r.repeat_count = 16'($urandom_range(4, 1));
        else
            r.repeat_count = 16'($urandom_range(16'hffff));
        r.handle = 5'($urandom_range(31));
        roll = $urandom_range(99);
        if (roll < 30)
            r.func = FUNC_TICK;
        else if (roll < 48)
            r.func = FUNC_ADD;
        else if (roll < 60)
            r.func = FUNC_DEL;
        else if (roll < 85)
            r.func = FUNC_POP;
        else if (roll < 97)
            r.func = FUNC_QUERY;
        else
            r.func = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_QUERY + 1));
        // most deletes name a live timer
        if (r.func == FUNC_DEL && $urandom_range(99) < 70) begin
            live = 0;
            foreach (slot_busy[s])
                if (slot_busy[s])
                    live++;
            if (live != 0) begin
                k = $urandom_range(live - 1);
                foreach (slot_busy[s]) begin
                    if (slot_busy[s]) begin
                        if (k == 0)
                            r.handle = 5'(s + 1);
                        k--;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic run_random_requests(int count);
        timer_req_t r;
        repeat (count) begin
            r = random_request();
            send_request(r.func, r.interval, r.repeat_count, r.handle);
        end
    endtask

    // Empty table, unknown handles, spare codes, count extremes, newest-due pick.
    task automatic test_directed_cases();
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
        send_request(FUNC_QUERY, 16'h0000, 16'sd0, 5'd0);     // empty table reads -1
        send_request(FUNC_POP,   16'h0000, 16'sd0, 5'd0);     // nothing due
        send_request(FUNC_DEL,   16'h0000, 16'sd0, 5'd0);     // handle 0 matches nothing
        send_request(FUNC_DEL,   16'h0000, 16'sd0, 5'd31);    // beyond the used slots
        send_request(FUNC_DEL,   16'h0000, 16'sd0, 5'd1);     // free slot
        for (int f = FUNC_QUERY + 1; f <= FUNC_SPARE_LAST; f++)
            send_request(3'(f), 16'hffff, -16'sd1, 5'd31);
        send_request(FUNC_ADD,   16'd0,     16'sd2,     5'd0);
        send_request(FUNC_ADD,   16'hffff,  -16'sd1,    5'd0);
        send_request(FUNC_ADD,   16'd3,     16'sh7fff,  5'd0);
        send_request(FUNC_ADD,   16'd0,     16'sd0,     5'd0);
        send_request(FUNC_ADD,   16'd0,     16'sh8000,  5'd0);
        send_request(FUNC_QUERY, 16'd0,     16'sd0,     5'd0);  // due now clamps to 0
        repeat (3)
            send_request(FUNC_POP, 16'd0, 16'sd0, 5'd0);        // newest due goes first
        repeat (4)
            send_request(FUNC_TICK, 16'd0, 16'sd0, 5'd0);
        send_request(FUNC_POP,   16'd0, 16'sd0, 5'd0);
        send_request(FUNC_QUERY, 16'd0, 16'sd0, 5'd0);
        send_request(FUNC_DEL,   16'd0, 16'sd0, 5'd2);
        send_request(FUNC_DEL,   16'd0, 16'sd0, 5'd2);          // already freed
        finish_phase();
    endtask

    // Fill every slot, overflow it, then free one and see it reused.
    task automatic test_full_table();
        timer_req_t r;
        repeat (USED_SLOTS + 2) begin
            r = random_request();
            send_request(FUNC_ADD, r.interval, r.repeat_count, r.handle);
        end
        send_request(FUNC_QUERY, 16'd0, 16'sd0, 5'd0);
        send_request(FUNC_DEL, 16'd0, 16'sd0, 5'($urandom_range(USED_SLOTS, 1)));
        r = random_request();
        send_request(FUNC_ADD, r.interval, r.repeat_count, r.handle);
        finish_phase();
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so the
    // output register and the engine fill and s_tready drops.
    task automatic test_output_hold_off();
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
        hold_trigger <= ~hold_trigger;
        run_random_requests(16);
        finish_phase();
    endtask

    task automatic test_no_idling();
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
        run_random_requests(275);
        finish_phase();
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct = 61;
        receiver_stall_pct <= 0;
        run_random_requests(275);
        finish_phase();
    endtask

    task automatic test_receiver_stalls();
        sender_idle_pct = 0;
        receiver_stall_pct <= 61;
        run_random_requests(275);
        finish_phase();
    endtask

    task automatic test_both_sides_idle();
        sender_idle_pct = 22;
        receiver_stall_pct <= 22;
        run_random_requests(275);
        finish_phase();
    endtask

    // Receiver: random back-pressure, or a counted hold-off when one is asked for.
    always @(posedge aclk) begin
        if (hold_trigger != hold_ack) begin
            hold_ack <= hold_trigger;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        timer_res_t got;
        timer_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.handle_out = m_tdata[4:0];
            got.min_wait = m_tdata[21:5];
            got.status = m_tdata[23:22];
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending, handle_out",
                                got.handle_out, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.handle_out !== want.handle_out)
                    report_mismatch("handle_out", got.handle_out, want.handle_out);
                if (got.min_wait !== want.min_wait)
                    report_mismatch("min_wait", got.min_wait, want.min_wait);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        // table state after reset: time and sequence at zero, every slot free
        tick_now = '0;
        add_seq = '0;
        foreach (slot_busy[s])
            slot_busy[s] = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_full_table();
        test_output_hold_off();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides_idle();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rtt_pkg.sv
rtl/repeating_timer_table.sv
test/repeating_timer_table_tb.sv
